// ----- rtl/epcal_pkg.sv -----
// Shared constants and the month table for the epoch-seconds to calendar-date converter.
// Depends on nothing; the converter in epoch_seconds_to_calendar_date.sv uses it.
package epcal_pkg;

    // Field widths of the ports.
    localparam int EPOCH_W = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;
    localparam int YDAY_W  = 9;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // First second past the supported span: 2100-01-01 00:00:00.
    localparam logic [EPOCH_W-1:0] LIMIT_SECONDS = 32'd4102444800;

    // Seconds per day split into a power of two and an odd part.
    localparam int DAY_SHIFT   = 7;
    localparam int DAY_ODD     = 675;
    localparam int SECS_PER_DAY = 86400;
    localparam int DAYS_W      = 16;
    localparam int SOD_W       = 17;

    // Counting from 1968-01-01, the start of a leap-first four-year cycle.
    localparam int DAYS_1968_TO_1970 = 731;
    localparam int DAYS_PER_QUAD     = 1461;
    localparam int DAYS_PER_YEAR     = 365;
    localparam int QUAD_BASE_YEAR    = 1968;
    localparam int QUAD_W            = 6;
    localparam int QREM_W            = 11;
    localparam int MINS_W            = 11;

    // Reciprocals, rounded up, that give exact quotients over each input range.
    localparam int DAY_K = 35;
    localparam logic [25:0] DAY_RECIP =
        26'(((64'd1 << DAY_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
    localparam int QUAD_K = 27;
    localparam logic [16:0] QUAD_RECIP =
        17'(((64'd1 << QUAD_K) + 64'(DAYS_PER_QUAD) - 64'd1) / 64'(DAYS_PER_QUAD));
    localparam int MIN_K = 23;
    localparam logic [17:0] MIN_RECIP =
        18'(((64'd1 << MIN_K) + 64'd59) / 64'd60);
    localparam int HOUR_K = 17;
    localparam logic [11:0] HOUR_RECIP =
        12'(((64'd1 << HOUR_K) + 64'd59) / 64'd60);

    // Zero-based day of year on which a month starts, with the leap day added
    // from March onward.
    function automatic logic [YDAY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [YDAY_W-1:0] base;
        begin
            case (m)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (m >= 4'd2)
            begin
                base = base + YDAY_W'(leap);
            end
            return base;
        end
    endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar_date.sv -----
// Pipelined converter from seconds since 1970-01-01 to calendar date and time of day.
// Depends on epcal_pkg (rtl/epcal_pkg.sv) for constants and the month table.
//
// Usage:
// A beat is offered by raising start with epoch_seconds; busy is always low, so
// every cycle with start high takes one beat. The converter is a seven-stage
// pipeline and takes a new beat every cycle. Once a beat has passed the stage
// registers in order, done is high for exactly one cycle together with year, month,
// day_of_month, day_of_year, hour, minute, second and out_of_range; the result
// is taken while done is high. Beats leave in the order they arrived, one per beat.
// The stages are set by the constant-divisor steps: the divide by seconds per day
// (a reciprocal multiply), its back-multiply, the remainder, the split into
// four-year cycles and minutes, their remainders with the hour, the split into
// years and minutes, and the month search that also forms the output register.
// A timestamp at or past 2100-01-01 00:00:00 gives out_of_range high and zeros in
// every date and time field.
// Reset clears only the valid bits of the stages, so done stays low until a beat
// has passed through. The receiver cannot stall; it must take each result in the
// cycle that done marks.
module epoch_seconds_to_calendar_date (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [epcal_pkg::EPOCH_W-1:0]      epoch_seconds,
    output logic                               done,
    output logic [epcal_pkg::YEAR_W-1:0]       year,
    output logic [epcal_pkg::MONTH_W-1:0]      month,
    output logic [epcal_pkg::MDAY_W-1:0]       day_of_month,
    output logic [epcal_pkg::YDAY_W-1:0]       day_of_year,
    output logic [epcal_pkg::HOUR_W-1:0]       hour,
    output logic [epcal_pkg::MIN_W-1:0]        minute,
    output logic [epcal_pkg::SEC_W-1:0]        second,
    output logic                               out_of_range
);

    localparam int NSTG = 7;

    // Valid and range flags travel with the data through every stage.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-2:0] oor_reg;

    // Stage 1: day count by reciprocal multiply.
    logic [epcal_pkg::EPOCH_W-1:0] t1_reg;
    logic [epcal_pkg::DAYS_W-1:0]  dq1_reg;
    logic [epcal_pkg::DAYS_W-1:0]  dq1_next;
    logic [50:0]                   dprod1;

    // Stage 2: days multiplied back to seconds.
    logic [epcal_pkg::EPOCH_W-1:0] t2_reg;
    logic [epcal_pkg::EPOCH_W-1:0] back2_reg;
    logic [epcal_pkg::DAYS_W-1:0]  dq2_reg;

    // Stage 3: second of day and day count from 1968.
    logic [epcal_pkg::DAYS_W-1:0]  days3_reg;
    logic [epcal_pkg::SOD_W-1:0]   sod3_reg;
    logic [epcal_pkg::EPOCH_W-1:0] diff3;

    // Stage 4: four-year cycle number and minute of day.
    logic [epcal_pkg::DAYS_W-1:0]  days4_reg;
    logic [epcal_pkg::SOD_W-1:0]   sod4_reg;
    logic [epcal_pkg::QUAD_W-1:0]  quad4_reg;
    logic [epcal_pkg::MINS_W-1:0]  mins4_reg;
    logic [32:0]                   qprod4;
    logic [34:0]                   mprod4;

    // Stage 5: day within the cycle, second, hour.
    logic [epcal_pkg::QUAD_W-1:0]  quad5_reg;
    logic [epcal_pkg::QREM_W-1:0]  qrem5_reg;
    logic [epcal_pkg::SEC_W-1:0]   sec5_reg;
    logic [epcal_pkg::MINS_W-1:0]  mins5_reg;
    logic [epcal_pkg::HOUR_W-1:0]  hour5_reg;
    logic [epcal_pkg::DAYS_W-1:0]  qback5;
    logic [epcal_pkg::SOD_W-1:0]   sback5;
    logic [22:0]                   hprod5;

    // Stage 6: year, zero-based day of year, minute.
    logic [epcal_pkg::YEAR_W-1:0]  year6_reg;
    logic [epcal_pkg::YDAY_W-1:0]  doy6_reg;
    logic                          leap6_reg;
    logic [epcal_pkg::HOUR_W-1:0]  hour6_reg;
    logic [epcal_pkg::MIN_W-1:0]   min6_reg;
    logic [epcal_pkg::SEC_W-1:0]   sec6_reg;
    logic [epcal_pkg::YEAR_W-1:0]  year6_next;
    logic [epcal_pkg::YDAY_W-1:0]  doy6_next;
    logic                          leap6_next;
    logic [epcal_pkg::QREM_W-1:0]  r6;
    logic [epcal_pkg::MINS_W-1:0]  hback6;

    // Stage 7: month search and the output register.
    logic [epcal_pkg::YEAR_W-1:0]  year_reg;
    logic [epcal_pkg::MONTH_W-1:0] month_reg;
    logic [epcal_pkg::MDAY_W-1:0]  mday_reg;
    logic [epcal_pkg::YDAY_W-1:0]  yday_reg;
    logic [epcal_pkg::HOUR_W-1:0]  hour_reg;
    logic [epcal_pkg::MIN_W-1:0]   min_reg;
    logic [epcal_pkg::SEC_W-1:0]   sec_reg;
    logic [epcal_pkg::MONTH_W-1:0] mon7_next;
    logic [epcal_pkg::YDAY_W-1:0]  mstart7;
    logic [epcal_pkg::YDAY_W-1:0]  mday7;

    logic accept;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Valid bits and range flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[NSTG-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        oor_reg <= {oor_reg[NSTG-3:0], (epoch_seconds >= epcal_pkg::LIMIT_SECONDS)};
    end

    // Stage 1: the divide by 86400 is a shift by 7 and an exact reciprocal
    // multiply for the odd factor 675.
    assign dprod1   = 51'(epoch_seconds[epcal_pkg::EPOCH_W-1:epcal_pkg::DAY_SHIFT])
                    * 51'(epcal_pkg::DAY_RECIP);
    assign dq1_next = dprod1[epcal_pkg::DAY_K +: epcal_pkg::DAYS_W];

    always_ff @(posedge clk)
    begin
        t1_reg  <= epoch_seconds;
        dq1_reg <= dq1_next;
    end

    // Stage 2.
    always_ff @(posedge clk)
    begin
        t2_reg    <= t1_reg;
        dq2_reg   <= dq1_reg;
        back2_reg <= epcal_pkg::EPOCH_W'(dq1_reg) * epcal_pkg::EPOCH_W'(epcal_pkg::SECS_PER_DAY);
    end

    // Stage 3: the quotient is exact, so the remainder is below one day.
    assign diff3 = t2_reg - back2_reg;

    always_ff @(posedge clk)
    begin
        sod3_reg  <= diff3[epcal_pkg::SOD_W-1:0];
        days3_reg <= dq2_reg + epcal_pkg::DAYS_W'(epcal_pkg::DAYS_1968_TO_1970);
    end

    // Stage 4: reciprocal multiplies for the four-year cycle and the minute of day.
    assign qprod4 = 33'(days3_reg) * 33'(epcal_pkg::QUAD_RECIP);
    assign mprod4 = 35'(sod3_reg) * 35'(epcal_pkg::MIN_RECIP);

    always_ff @(posedge clk)
    begin
        days4_reg <= days3_reg;
        sod4_reg  <= sod3_reg;
        quad4_reg <= qprod4[epcal_pkg::QUAD_K +: epcal_pkg::QUAD_W];
        mins4_reg <= mprod4[epcal_pkg::MIN_K +: epcal_pkg::MINS_W];
    end

    // Stage 5: remainders of those divides and the hour.
    assign qback5 = epcal_pkg::DAYS_W'(quad4_reg) * epcal_pkg::DAYS_W'(epcal_pkg::DAYS_PER_QUAD);
    assign sback5 = epcal_pkg::SOD_W'(mins4_reg) * epcal_pkg::SOD_W'(60);
    assign hprod5 = 23'(mins4_reg) * 23'(epcal_pkg::HOUR_RECIP);

    always_ff @(posedge clk)
    begin
        quad5_reg <= quad4_reg;
        mins5_reg <= mins4_reg;
        qrem5_reg <= epcal_pkg::QREM_W'(days4_reg - qback5);
        sec5_reg  <= epcal_pkg::SEC_W'(sod4_reg - sback5);
        hour5_reg <= hprod5[epcal_pkg::HOUR_K +: epcal_pkg::HOUR_W];
    end

    // Stage 6: the first year of each cycle is the leap year with 366 days,
    // the three after it have 365.
    assign r6     = qrem5_reg - epcal_pkg::QREM_W'(epcal_pkg::DAYS_PER_YEAR + 1);
    assign hback6 = epcal_pkg::MINS_W'(hour5_reg) * epcal_pkg::MINS_W'(60);

    always_comb
    begin
        year6_next = epcal_pkg::YEAR_W'(epcal_pkg::QUAD_BASE_YEAR)
                   + epcal_pkg::YEAR_W'({quad5_reg, 2'b00});
        doy6_next  = epcal_pkg::YDAY_W'(qrem5_reg);
        leap6_next = 1'b1;
        if (qrem5_reg >= epcal_pkg::QREM_W'(epcal_pkg::DAYS_PER_YEAR + 1))
        begin
            leap6_next = 1'b0;
            if (r6 < epcal_pkg::QREM_W'(epcal_pkg::DAYS_PER_YEAR))
            begin
                year6_next = year6_next + 12'd1;
                doy6_next  = epcal_pkg::YDAY_W'(r6);
            end
            else if (r6 < epcal_pkg::QREM_W'(2 * epcal_pkg::DAYS_PER_YEAR))
            begin
                year6_next = year6_next + 12'd2;
                doy6_next  = epcal_pkg::YDAY_W'(r6 - epcal_pkg::QREM_W'(epcal_pkg::DAYS_PER_YEAR));
            end
            else
            begin
                year6_next = year6_next + 12'd3;
                doy6_next  = epcal_pkg::YDAY_W'(r6
                           - epcal_pkg::QREM_W'(2 * epcal_pkg::DAYS_PER_YEAR));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        year6_reg <= year6_next;
        doy6_reg  <= doy6_next;
        leap6_reg <= leap6_next;
        hour6_reg <= hour5_reg;
        min6_reg  <= epcal_pkg::MIN_W'(mins5_reg - hback6);
        sec6_reg  <= sec5_reg;
    end

    // Stage 7: eleven parallel compares against the month starts; the last one
    // passed names the month.
    always_comb
    begin
        mon7_next = '0;
        for (int m = 1; m < 12; m++)
        begin
            if (doy6_reg >= epcal_pkg::month_start(epcal_pkg::MONTH_W'(m), leap6_reg))
            begin
                mon7_next = epcal_pkg::MONTH_W'(m);
            end
        end
        mstart7 = epcal_pkg::month_start(mon7_next, leap6_reg);
        mday7   = doy6_reg - mstart7 + 9'd1;
    end

    always_ff @(posedge clk)
    begin
        if (oor_reg[NSTG-2])
        begin
            year_reg  <= '0;
            month_reg <= '0;
            mday_reg  <= '0;
            yday_reg  <= '0;
            hour_reg  <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
        end
        else
        begin
            year_reg  <= year6_reg;
            month_reg <= mon7_next + 4'd1;
            mday_reg  <= mday7[epcal_pkg::MDAY_W-1:0];
            yday_reg  <= doy6_reg + 9'd1;
            hour_reg  <= hour6_reg;
            min_reg   <= min6_reg;
            sec_reg   <= sec6_reg;
        end
        out_of_range <= oor_reg[NSTG-2];
    end

    assign done         = vld_reg[NSTG-1];
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = mday_reg;
    assign day_of_year  = yday_reg;
    assign hour         = hour_reg;
    assign minute       = min_reg;
    assign second       = sec_reg;

endmodule
